FILE: src/fts_pkg.sv
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types and constants for the FIFO replacement tag store.
// ----------------------------------------------------------------------------
package fts_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int ADDR_W          = 64;
    localparam int CAP_W           = 7;
    localparam int OCC_W           = 7;
    localparam int CTR_W           = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } fts_state_t;

    typedef struct packed {
        logic start;
        logic issue;
        logic update;
    } fts_cmd_t;

    typedef struct packed {
        logic fill_zero;
        logic last_issue;
        logic out_free;
    } fts_status_t;

endpackage

FILE: src/fts_ctrl.sv
// ----------------------------------------------------------------------------
// fts_ctrl
// Sequencer: accept an address, scan the valid ring entries, then update.
// ----------------------------------------------------------------------------
module fts_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  fts_pkg::fts_status_t status,
    output fts_pkg::fts_cmd_t    cmd
);
    import fts_pkg::*;

    fts_state_t state_reg;
    fts_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = status.fill_zero ? ST_UPDATE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (status.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (status.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/fts_datapath.sv
// ----------------------------------------------------------------------------
// fts_datapath
// Entry ring memory, pointers, compare, counters and result register.
// ----------------------------------------------------------------------------
module fts_datapath #(
    parameter int MAX_ENTRIES = fts_pkg::MAX_ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [fts_pkg::CAP_W-1:0]    cfg_wr_data,
    input  logic [fts_pkg::ADDR_W-1:0]   s_access_address,
    input  fts_pkg::fts_cmd_t            cmd,
    output fts_pkg::fts_status_t         status,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic                         m_evicted,
    output logic [fts_pkg::ADDR_W-1:0]   m_victim_address,
    output logic [fts_pkg::OCC_W-1:0]    m_occupancy,
    output logic [fts_pkg::CTR_W-1:0]    m_hit_total,
    output logic [fts_pkg::CTR_W-1:0]    m_miss_total,
    output logic [fts_pkg::CTR_W-1:0]    m_eviction_total
);
    import fts_pkg::*;

    localparam int PTR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [ADDR_W-1:0] ring [MAX_ENTRIES];

    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  cap_eff;
    logic [PTR_W-1:0]  oldest_reg, oldest_next;
    logic [PTR_W-1:0]  insert_reg, insert_next;
    logic [PTR_W-1:0]  scan_ptr_reg;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  idx_reg;
    logic [CTR_W-1:0]  hit_cnt_reg, hit_cnt_next;
    logic [CTR_W-1:0]  miss_cnt_reg, miss_cnt_next;
    logic [CTR_W-1:0]  evict_cnt_reg, evict_cnt_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic              rd_first_reg;
    logic [ADDR_W-1:0] victim_reg;
    logic              found_reg;
    logic              m_valid_reg;
    logic              full;
    logic              evict;
    logic [31:0]       cap_raw32;
    logic [31:0]       fill_ext;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] cap);
        logic [31:0] t;
        t = 32'(p) + 32'd1;
        return (t >= 32'(cap)) ? '0 : t[PTR_W-1:0];
    endfunction

    assign cap_raw32 = 32'(cap_reg);

    always_comb begin
        if (cap_raw32 == 32'd0) begin
            cap_eff = CNT_W'(1);
        end else if (cap_raw32 > 32'(MAX_ENTRIES)) begin
            cap_eff = CNT_W'(MAX_ENTRIES);
        end else begin
            cap_eff = CNT_W'(cap_raw32);
        end
    end

    assign status.fill_zero  = (fill_reg == '0);
    assign status.last_issue = ((32'(idx_reg) + 32'd1) == 32'(fill_reg));
    assign status.out_free   = !m_valid_reg || m_ready;

    assign full  = (32'(fill_reg) >= 32'(cap_eff));
    assign evict = !found_reg && full;

    always_comb begin
        oldest_next    = oldest_reg;
        insert_next    = insert_reg;
        fill_next      = fill_reg;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        evict_cnt_next = evict_cnt_reg;
        if (found_reg) begin
            if (hit_cnt_reg != '1) hit_cnt_next = hit_cnt_reg + CTR_W'(1);
        end else begin
            if (miss_cnt_reg != '1) miss_cnt_next = miss_cnt_reg + CTR_W'(1);
            insert_next = next_ptr(insert_reg, cap_eff);
            if (full) begin
                oldest_next = next_ptr(oldest_reg, cap_eff);
                fill_next   = cap_eff;
                if (evict_cnt_reg != '1) evict_cnt_next = evict_cnt_reg + CTR_W'(1);
            end else begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
    end

    assign fill_ext = 32'(fill_next);

    // ring memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.update && !found_reg) begin
            ring[insert_reg] <= addr_reg;
        end
        if (cmd.issue) begin
            rd_data_reg <= ring[scan_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_RESET;
            oldest_reg    <= '0;
            insert_reg    <= '0;
            fill_reg      <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            rd_valid_reg  <= 1'b0;
            rd_first_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.issue;
            rd_first_reg <= cmd.issue && (idx_reg == '0);
            if (cfg_wr_en) begin
                cap_reg    <= cfg_wr_data;
                oldest_reg <= '0;
                insert_reg <= '0;
                fill_reg   <= '0;
            end else if (cmd.update) begin
                oldest_reg <= oldest_next;
                insert_reg <= insert_next;
                fill_reg   <= fill_next;
            end
            if (cmd.update) begin
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    // scan state and result payload
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            addr_reg     <= s_access_address;
            scan_ptr_reg <= oldest_reg;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
        end else begin
            if (cmd.issue) begin
                scan_ptr_reg <= next_ptr(scan_ptr_reg, cap_eff);
                idx_reg      <= idx_reg + CNT_W'(1);
            end
            if (rd_valid_reg && (rd_data_reg == addr_reg)) begin
                found_reg <= 1'b1;
            end
        end
        if (rd_first_reg) begin
            victim_reg <= rd_data_reg;
        end
        if (cmd.update) begin
            m_hit            <= found_reg;
            m_evicted        <= evict;
            m_victim_address <= evict ? victim_reg : '0;
            m_occupancy      <= fill_ext[OCC_W-1:0];
            m_hit_total      <= hit_cnt_next;
            m_miss_total     <= miss_cnt_next;
            m_eviction_total <= evict_cnt_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: src/fifo_replacement_tag_store_top.sv
// ----------------------------------------------------------------------------
// fifo_replacement_tag_store_top
// Fully associative tag store with first-in first-out replacement.
//
// Input channel s_*: one access address per transfer. Result channel m_*:
// one result per input, giving hit, eviction and victim, occupancy after
// the access and saturating hit, miss and eviction totals.
// Configuration: cfg_wr_en writes cfg_wr_data into the capacity register
// and empties the store; the totals are kept.
// Flow: after the transfer the lookup scans the F entries held before
// the access, drains the read port and updates; into an empty store it
// goes straight to the update. The ring is one memory with a single
// registered read port, so the lookup reads one entry per cycle. One
// item is in flight at a time; s_ready is high again the cycle after the
// result is loaded. No new address is taken before the last one is done.
// A finished result waits in the output register while the next address is
// taken and scanned; the update stalls only if that register is still full.
// Reset: store empty, totals zero, capacity 64.
// ----------------------------------------------------------------------------
module fifo_replacement_tag_store_top #(
    parameter int MAX_ENTRIES = fts_pkg::MAX_ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [fts_pkg::CAP_W-1:0]    cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [fts_pkg::ADDR_W-1:0]   s_access_address,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic                         m_evicted,
    output logic [fts_pkg::ADDR_W-1:0]   m_victim_address,
    output logic [fts_pkg::OCC_W-1:0]    m_occupancy,
    output logic [fts_pkg::CTR_W-1:0]    m_hit_total,
    output logic [fts_pkg::CTR_W-1:0]    m_miss_total,
    output logic [fts_pkg::CTR_W-1:0]    m_eviction_total
);
    import fts_pkg::*;

    fts_cmd_t    cmd;
    fts_status_t status;

    fts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fts_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_access_address (s_access_address),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hit            (m_hit),
        .m_evicted        (m_evicted),
        .m_victim_address (m_victim_address),
        .m_occupancy      (m_occupancy),
        .m_hit_total      (m_hit_total),
        .m_miss_total     (m_miss_total),
        .m_eviction_total (m_eviction_total)
    );

endmodule

FILE: src/fts_checker.sv
// ----------------------------------------------------------------------------
// fts_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module fts_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_hit,
    input logic                         m_evicted,
    input logic [fts_pkg::ADDR_W-1:0]   m_victim_address,
    input logic [fts_pkg::OCC_W-1:0]    m_occupancy
);
    import fts_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_victim_address)
                                   && $stable(m_occupancy)))
        else $error("result changed while stalled");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit) |-> !m_evicted)
        else $error("hit reported with eviction");

    a_victim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_evicted) |-> (m_victim_address == '0))
        else $error("victim address without eviction");

    a_occ_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_occupancy != '0))
        else $error("empty store after an access");

endmodule

bind fifo_replacement_tag_store_top fts_checker u_fts_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_hit            (m_hit),
    .m_evicted        (m_evicted),
    .m_victim_address (m_victim_address),
    .m_occupancy      (m_occupancy)
);

FILE: tb/sv/fifo_replacement_tag_store_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_replacement_tag_store_top_tb
// Self-checking bench for the FIFO replacement tag store. A behavioural copy
// of the ring, its pointers and the saturating totals predicts one result per
// address transfer. Directed cases cover reset capacity, the single entry,
// out-of-range capacity values, replacement order and the emptying on a
// capacity write. Random phases then sweep capacities with address pools
// sized to mix hits and evictions. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module fifo_replacement_tag_store_top_tb;

    import fts_pkg::*;

    localparam int RING_DEPTH   = MAX_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 1250;
    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE       = 8;
    localparam int DRAIN_CYCLES = 100;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic              hit;
        logic              evicted;
        logic [ADDR_W-1:0] victim_address;
        logic [OCC_W-1:0]  occupancy;
        logic [CTR_W-1:0]  hit_total;
        logic [CTR_W-1:0]  miss_total;
        logic [CTR_W-1:0]  eviction_total;
    } tag_result_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [CAP_W-1:0]  cfg_wr_data;
    logic              s_valid;
    logic              s_ready;
    logic [ADDR_W-1:0] s_access_address;
    logic              m_valid;
    logic              m_ready;
    logic              m_hit;
    logic              m_evicted;
    logic [ADDR_W-1:0] m_victim_address;
    logic [OCC_W-1:0]  m_occupancy;
    logic [CTR_W-1:0]  m_hit_total;
    logic [CTR_W-1:0]  m_miss_total;
    logic [CTR_W-1:0]  m_eviction_total;

    // behavioural copy of the store
    logic [ADDR_W-1:0] slot_addr [RING_DEPTH];
    int unsigned       head_idx;
    int unsigned       tail_idx;
    int unsigned       held_count;
    logic [CTR_W-1:0]  hits;
    logic [CTR_W-1:0]  misses;
    logic [CTR_W-1:0]  evictions;
    logic [CAP_W-1:0]  cap_reg;

    tag_result_t       pending_results [$];
    logic [ADDR_W-1:0] addr_pool [$];
    int unsigned       fail_count;
    int unsigned       idle_cycles;
    int unsigned       random_sent;
    bit                steady;

    fifo_replacement_tag_store_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_access_address (s_access_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hit            (m_hit),
        .m_evicted        (m_evicted),
        .m_victim_address (m_victim_address),
        .m_occupancy      (m_occupancy),
        .m_hit_total      (m_hit_total),
        .m_miss_total     (m_miss_total),
        .m_eviction_total (m_eviction_total)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int unsigned effective_capacity(logic [CAP_W-1:0] raw);
        if (raw == '0) begin
            return 1;
        end
        if (32'(raw) > RING_DEPTH) begin
            return RING_DEPTH;
        end
        return 32'(raw);
    endfunction

    function automatic tag_result_t lookup_and_replace(logic [ADDR_W-1:0] addr);
        tag_result_t r;
        int unsigned cap;
        int unsigned p;
        logic        found;
        cap   = effective_capacity(cap_reg);
        found = 1'b0;
        p     = head_idx;
        r     = '0;
        for (int unsigned i = 0; i < held_count && i < cap; i++) begin
            if (slot_addr[p] == addr) begin
                found = 1'b1;
            end
            p = (p + 1 >= cap) ? 0 : p + 1;
        end
        if (found) begin
            if (hits != '1) hits++;
        end else begin
            if (misses != '1) misses++;
            if (held_count >= cap) begin
                r.evicted        = 1'b1;
                r.victim_address = slot_addr[head_idx];
                head_idx         = (head_idx + 1 >= cap) ? 0 : head_idx + 1;
                held_count       = cap - 1;
                if (evictions != '1) evictions++;
            end
            slot_addr[tail_idx] = addr;
            tail_idx            = (tail_idx + 1 >= cap) ? 0 : tail_idx + 1;
            held_count++;
        end
        r.hit            = found;
        r.occupancy      = held_count[OCC_W-1:0];
        r.hit_total      = hits;
        r.miss_total     = misses;
        r.eviction_total = evictions;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] random_address();
        return {$urandom, $urandom};
    endfunction

    task automatic report_failure(string what, tag_result_t want, tag_result_t got);
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
            $display("%0t %s: expected hit=%0b ev=%0b victim=%h occ=%0d h=%0d m=%0d e=%0d",
                     $realtime, what, want.hit, want.evicted, want.victim_address,
                     want.occupancy, want.hit_total, want.miss_total, want.eviction_total);
            $display("%0t %s:   actual hit=%0b ev=%0b victim=%h occ=%0d h=%0d m=%0d e=%0d",
                     $realtime, what, got.hit, got.evicted, got.victim_address,
                     got.occupancy, got.hit_total, got.miss_total, got.eviction_total);
        end
    endtask

    // send one address, predicting its result at the transfer
    task automatic send_access(logic [ADDR_W-1:0] addr);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_access_address <= addr;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(lookup_and_replace(addr));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        cap_reg    = value;
        head_idx   = 0;
        tail_idx   = 0;
        held_count = 0;
        repeat (2) @(posedge aclk);
    endtask

    task automatic test_default_capacity();
        send_access('0);
        send_access('1);
        send_access('0);
        send_access('1);
    endtask

    task automatic test_single_entry();
        set_capacity(7'd1);
        send_access(64'h0123_4567_89AB_CDEF);
        send_access(64'h0123_4567_89AB_CDEF);
        send_access(64'hFEDC_BA98_7654_3210);
        send_access(64'h0123_4567_89AB_CDEF);
    endtask

    task automatic test_zero_capacity();
        set_capacity(7'd0);
        send_access(64'h8000_0000_0000_0000);
        send_access(64'h0000_0000_0000_0001);
        send_access(64'h0000_0000_0000_0001);
    endtask

    task automatic test_oversize_capacity();
        set_capacity(7'h7F);
        send_access(64'hAAAA_AAAA_AAAA_AAAA);
        send_access(64'h5555_5555_5555_5555);
    endtask

    // a hit must not refresh the entry's place in the ring
    task automatic test_fifo_order();
        set_capacity(7'd3);
        send_access(64'd10);
        send_access(64'd11);
        send_access(64'd12);
        send_access(64'd10);
        send_access(64'd13);
        send_access(64'd10);
    endtask

    task automatic test_write_empties_store();
        set_capacity(7'd3);
        send_access(64'd13);
        send_access(64'd12);
    endtask

    task automatic test_random_phases();
        logic [CAP_W-1:0] cap;
        int unsigned      r;
        int unsigned      eff;
        int unsigned      n;
        int unsigned      pool_size;
        logic [ADDR_W-1:0] addr;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                cap = CAP_W'($urandom_range(1, 8));
            end else if (r < 65) begin
                cap = CAP_W'($urandom_range(9, 24));
            end else if (r < 75) begin
                cap = CAP_W'($urandom_range(25, 63));
            end else if (r < 85) begin
                cap = 7'd64;
            end else if (r < 95) begin
                cap = CAP_W'($urandom_range(65, 127));
            end else begin
                cap = 7'd0;
            end
            set_capacity(cap);
            eff       = effective_capacity(cap);
            n         = (eff > 24) ? eff * 2 + 20 : $urandom_range(40, 80);
            pool_size = eff + $urandom_range(0, eff / 2) + 1;
            steady    = ($urandom_range(0, 3) == 0);
            addr_pool.delete();
            for (int unsigned k = 0; k < pool_size; k++) begin
                // neighbours one bit apart stress the full-width compare
                if (k > 0 && $urandom_range(0, 2) == 0) begin
                    addr_pool.push_back(addr_pool[k-1] ^ (64'd1 << $urandom_range(0, 63)));
                end else begin
                    addr_pool.push_back(random_address());
                end
            end
            repeat (n) begin
                if ($urandom_range(0, 99) < 85) begin
                    addr = addr_pool[$urandom_range(0, pool_size - 1)];
                end else begin
                    addr = random_address();
                end
                send_access(addr);
                random_sent++;
            end
            steady = 1'b0;
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        tag_result_t got;
        tag_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_hit, m_evicted, m_victim_address, m_occupancy,
                    m_hit_total, m_miss_total, m_eviction_total};
            if (pending_results.size() == 0) begin
                report_failure("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    report_failure("mismatch", want, got);
                end
            end
        end
    end

    // result channel back-pressure
    initial begin
        int unsigned run;
        int unsigned stall;
        forever begin
            run = $urandom_range(1, 30);
            repeat (run) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
            stall = steady ? 0 : pick_gap();
            repeat (stall) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        aclk             = 1'b0;
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        s_valid          = 1'b0;
        s_access_address = '0;
        m_ready          = 1'b0;
        fail_count       = 0;
        steady           = 1'b0;
        head_idx         = 0;
        tail_idx         = 0;
        held_count       = 0;
        hits             = '0;
        misses           = '0;
        evictions        = '0;
        cap_reg          = CAP_RESET;
        foreach (slot_addr[i]) slot_addr[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_default_capacity();
        test_single_entry();
        test_zero_capacity();
        test_oversize_capacity();
        test_fifo_order();
        test_write_empties_store();
        test_random_phases();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        while (pending_results.size() != 0) begin
            report_failure("missing result", pending_results.pop_front(), '0);
        end
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
